@@ design/swp_pkg.sv @@
package swp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SlotW   = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEL,
    ST_INS
  } swp_state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DEL,
    OP_INS
  } swp_op_e;

  typedef struct packed {
    swp_op_e              op;
    logic [SampleW-1:0]   key;
  } swp_cell_ctrl_t;

endpackage

@@ design/swp_ring.sv @@
module swp_ring import swp_pkg::*; #(
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   addr_i,
  input  logic [SampleW-1:0] wdata_i,
  output logic [SampleW-1:0] rdata_o
);

  logic [SampleW-1:0] mem_q [Depth];
  logic [SampleW-1:0] rdata_q;

  // read-first: the registered read returns the value being overwritten
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/swp_cell.sv @@
module swp_cell import swp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swp_cell_ctrl_t     ctrl_i,
  input  logic               top_i,
  input  logic [SampleW-1:0] left_val_i,
  input  logic               left_flag_i,
  input  logic [SampleW-1:0] right_val_i,
  output logic [SampleW-1:0] value_o,
  output logic               flag_o
);

  logic [SampleW-1:0] val_q, val_d;

  // del: flag marks cells at or above the evicted value, which take the right neighbor
  // ins: flag marks cells above the new value, which shift up by one
  always_comb begin
    flag_o = 1'b0;
    val_d  = val_q;
    case (ctrl_i.op)
      OP_DEL: begin
        flag_o = (val_q >= ctrl_i.key);
        val_d  = flag_o ? right_val_i : val_q;
      end
      OP_INS: begin
        flag_o = (val_q > ctrl_i.key) || top_i;
        if (left_flag_i) begin
          val_d = left_val_i;
        end else if (flag_o) begin
          val_d = ctrl_i.key;
        end
      end
      default: begin
        flag_o = 1'b0;
        val_d  = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign value_o = val_q;

endmodule

@@ design/sliding_window_percentiles.sv @@
// Sliding-window percentile block.
// Input channel: in_valid_i/in_ready_o carry one item, a Q8.8 ms sample_i.
// Output channel: out_valid_o/out_ready_i carry one result per item: the
// window entries at the 50, 95 and 99 percent ranks, the maximum, and the
// ring slot that the sample overwrote.
// The sample is written to a ring memory whose registered read returns the
// evicted value. A chain of WINDOW cells holds the window in ascending order;
// in one cycle every cell compares against the evicted value and closes the
// gap, in the next every cell compares against the new sample and opens one.
// Each item passes through the delete and insert steps of the cell chain, then
// the output register; a new item is taken during the previous insert step.
// While a result waits in the output register, the next item is taken and
// finished in the cell chain; the item after that is taken too, and its
// delete step, with in_ready_o low, holds until the waiting result is taken.
// Reset: ring and cells read as zero and take part in the statistics; ring
// slots not yet written since reset read as zero through a wrap flag, so no
// clearing pass is needed and the block is ready right after reset.
module sliding_window_percentiles import swp_pkg::*; #(
  parameter int unsigned WINDOW = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] median_o,
  output logic [SampleW-1:0] pct95_o,
  output logic [SampleW-1:0] pct99_o,
  output logic [SampleW-1:0] largest_o,
  output logic [SlotW-1:0]   slot_written_o
);

  localparam int unsigned AddrW  = $clog2(WINDOW);
  localparam int unsigned IdxP50 = (WINDOW * 50) / 100;
  localparam int unsigned IdxP95 = (WINDOW * 95) / 100;
  localparam int unsigned IdxP99 = (WINDOW * 99) / 100;

  swp_state_e state_q, state_d;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               del_go;
  swp_cell_ctrl_t     cell_ctrl;

  logic [AddrW-1:0]   pos_q;
  logic               wrapped_q;
  logic [AddrW-1:0]   cur_pos_q;
  logic               seen_q;
  logic [SampleW-1:0] samp_q;
  logic               pend_q, pend_d;
  logic [AddrW-1:0]   pend_pos_q;
  logic [SampleW-1:0] ring_rdata;

  logic               out_valid_q;
  logic [SampleW-1:0] median_q, pct95_q, pct99_q, largest_q;
  logic [SlotW-1:0]   slot_q;

  logic [SampleW-1:0] cell_val [WINDOW];
  logic [WINDOW-1:0]  cell_flag;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign del_go   = !pend_q || out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DEL;
      ST_DEL:  if (del_go) state_d = ST_INS;
      ST_INS:  state_d = accept ? ST_DEL : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o    = 1'b0;
    cell_ctrl.op  = OP_HOLD;
    cell_ctrl.key = samp_q;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        out_load   = pend_q && out_free;
      end
      ST_DEL: begin
        out_load      = pend_q && out_free;
        cell_ctrl.op  = del_go ? OP_DEL : OP_HOLD;
        cell_ctrl.key = seen_q ? ring_rdata : '0;
      end
      ST_INS: begin
        in_ready_o   = 1'b1;
        cell_ctrl.op = OP_INS;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (state_q == ST_INS) begin
      pend_d = 1'b1;
    end else if (out_load) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (accept) begin
        if (pos_q == AddrW'(WINDOW - 1)) begin
          pos_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_pos_q <= pos_q;
      seen_q    <= wrapped_q;
      samp_q    <= sample_i;
    end
    if (state_q == ST_INS) begin
      pend_pos_q <= cur_pos_q;
    end
    if (out_load) begin
      median_q  <= cell_val[IdxP50];
      pct95_q   <= cell_val[IdxP95];
      pct99_q   <= cell_val[IdxP99];
      largest_q <= cell_val[WINDOW-1];
      slot_q    <= SlotW'(pend_pos_q);
    end
  end

  swp_ring #(
    .Depth (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .addr_i  (pos_q),
    .wdata_i (sample_i),
    .rdata_o (ring_rdata)
  );

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SampleW-1:0] left_val;
    logic               left_flag;
    logic [SampleW-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val  = '0;
      assign left_flag = 1'b0;
    end else begin : g_inner_l
      assign left_val  = cell_val[i-1];
      assign left_flag = cell_flag[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_val = '1;
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
    end

    swp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .top_i       (i == WINDOW - 1),
      .left_val_i  (left_val),
      .left_flag_i (left_flag),
      .right_val_i (right_val),
      .value_o     (cell_val[i]),
      .flag_o      (cell_flag[i])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign median_o       = median_q;
  assign pct95_o        = pct95_q;
  assign pct99_o        = pct99_q;
  assign largest_o      = largest_q;
  assign slot_written_o = slot_q;

  a_no_accept_in_del : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEL) |-> !in_ready_o)
    else $error("item accepted during delete step");

  a_load_needs_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> pend_q)
    else $error("output loaded without a finished item");

  a_ins_sets_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |=> pend_q)
    else $error("finished item not marked pending");

  a_del_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEL && pend_q && !out_free) |=> (state_q == ST_DEL && pend_q))
    else $error("delete step ran over an unread result");

  a_chain_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cell_val[0] <= cell_val[1]))
    else $error("cell chain out of order");

endmodule
